>>> hw/rtl/c2s_pkg.sv
package c2s_pkg;

    localparam int CORDIC_STAGES_DEF = 30;
    localparam int SQRT_CELLS = 32;
    localparam logic [63:0] FRAC_ONE = 64'd1 << 61;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic orig;
        logic xy_zero;
    } c2s_flags_t;

    // Restoring long division, used only while the constant tables are built.
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q61 as the alternating series, each term truncated.
    function automatic logic [63:0] atan_recip(logic [63:0] m);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        t = udiv64(FRAC_ONE, m);
        sum = 64'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (t != 64'd0)
            begin
                term = udiv64(t, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
                t = udiv64(udiv64(t, m), m);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_entry(int i);
        if (i == 0)
            return atan_recip(64'd2) + atan_recip(64'd3);
        else
            return atan_recip(64'd1 << i);
    endfunction

    // CORDIC gain in Q29, taken from a run on the unit vector along x.
    function automatic logic [29:0] cordic_gain_q29(int n);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] k;
        x = 64'd1 << 60;
        y = 64'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (i < n)
            begin
                dx = 64'($signed(y) >>> i);
                dy = 64'($signed(x) >>> i);
                if (!y[63])
                begin
                    x = x + dx;
                    y = y - dy;
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                end
            end
        end
        k = (x + (64'd1 << 30)) >> 31;
        return k[29:0];
    endfunction

    localparam logic [63:0] HALF_PI = 64'(2 * atan_entry(0));
    localparam logic [63:0] FULL_PI = 64'(2 * HALF_PI);

endpackage

>>> hw/rtl/c2s_delay.sv
module c2s_delay
    import c2s_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    generate
        if (DEPTH == 0)
        begin : g_none
            assign q = d;
        end
        else
        begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];
            always_ff @(posedge clk)
            begin
                tap_reg[0] <= d;
                for (int i = 1; i < DEPTH; i++)
                    tap_reg[i] <= tap_reg[i-1];
            end
            assign q = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

>>> hw/rtl/c2s_sqrt_cell.sv
module c2s_sqrt_cell
    import c2s_pkg::*;
#(
    parameter int BIT_POS = 62
)
(
    input  logic        clk,
    input  logic [63:0] rem_in,
    input  logic [63:0] root_in,
    output logic [63:0] rem_reg,
    output logic [63:0] root_reg
);

    localparam logic [63:0] BITV = 64'd1 << BIT_POS;

    logic [63:0] trial;
    logic [64:0] diff;
    logic [63:0] rem_next;
    logic [63:0] root_next;

    // One result bit per cell: the trial subtract decides the bit.
    always_comb
    begin
        trial = root_in + BITV;
        diff = {1'b0, rem_in} - {1'b0, trial};
        if (!diff[64])
        begin
            rem_next = diff[63:0];
            root_next = (root_in >> 1) + BITV;
        end
        else
        begin
            rem_next = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

endmodule

>>> hw/rtl/c2s_cordic_cell.sv
module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic        clk,
    input  logic [63:0] x_in,
    input  logic [63:0] y_in,
    input  logic [63:0] acc_in,
    output logic [63:0] x_reg,
    output logic [63:0] y_reg,
    output logic [63:0] acc_reg
);

    localparam logic [63:0] ATAN = atan_entry(SHIFT);

    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] x_next;
    logic [63:0] y_next;
    logic [63:0] acc_next;

    // Rotate towards y = 0; y = 0 counts as non-negative.
    always_comb
    begin
        dx = 64'($signed(y_in) >>> SHIFT);
        dy = 64'($signed(x_in) >>> SHIFT);
        if (!y_in[63])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            acc_next = acc_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            acc_next = acc_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
    end

endmodule

>>> hw/rtl/cartesian_to_spherical.sv
// Channel   Handshake          Payload
// input     start, busy        pos_x, pos_y, pos_z
// result    done (strobe)      range_len, incl_angle, azim_angle, at_origin
//
// One item is taken in every cycle; busy stays low.
// Each result passes the input register, the square register, the two CORDIC
// cell chains in series, the fold and output registers; the range runs alongside.
// Reset clears only the valid line; no result is shown for items in flight.
// The receiver cannot stall: done is high for exactly one cycle per item.
module cartesian_to_spherical
    import c2s_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               done,
    output logic        [31:0] range_len,
    output logic        [30:0] incl_angle,
    output logic signed [31:0] azim_angle,
    output logic               at_origin
);

    localparam int LAT = 4 + 2 * CORDIC_STAGES;
    localparam int RANGE_DLY = 2 * CORDIC_STAGES - SQRT_CELLS;
    localparam logic [29:0] KQ = cordic_gain_q29(CORDIC_STAGES);

    logic [LAT-1:0] vld_reg;

    logic [31:0] mx1_reg, my1_reg, mz1_reg;
    logic        nx1_reg, ny1_reg, nz1_reg, orig1_reg;

    logic [63:0] sqx_reg, sqy_reg, sqz_reg, zk2_reg;
    logic [31:0] mx2_reg, my2_reg;
    c2s_flags_t  fl2_reg;
    logic [63:0] sum_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    always_ff @(posedge clk)
    begin
        mx1_reg <= pos_x[31] ? 32'(~pos_x + 32'sd1) : 32'(pos_x);
        my1_reg <= pos_y[31] ? 32'(~pos_y + 32'sd1) : 32'(pos_y);
        mz1_reg <= pos_z[31] ? 32'(~pos_z + 32'sd1) : 32'(pos_z);
        nx1_reg <= pos_x[31];
        ny1_reg <= pos_y[31];
        nz1_reg <= pos_z[31];
        orig1_reg <= (pos_x == 32'sd0) && (pos_y == 32'sd0) && (pos_z == 32'sd0);

        sqx_reg <= 64'(mx1_reg) * 64'(mx1_reg);
        sqy_reg <= 64'(my1_reg) * 64'(my1_reg);
        sqz_reg <= 64'(mz1_reg) * 64'(mz1_reg);
        zk2_reg <= 64'(mz1_reg * 62'(KQ));
        mx2_reg <= mx1_reg;
        my2_reg <= my1_reg;
        fl2_reg <= '{neg_x: nx1_reg, neg_y: ny1_reg, neg_z: nz1_reg, orig: orig1_reg,
                     xy_zero: (mx1_reg == 32'd0) && (my1_reg == 32'd0)};
    end

    // The three squares stay below 2^64, so the sum needs no extra bit.
    assign sum_sq = sqx_reg + sqy_reg + sqz_reg;

    // Range: one square-root bit per cell, then round to nearest.
    logic [63:0] sq_rem  [SQRT_CELLS+1];
    logic [63:0] sq_root [SQRT_CELLS+1];
    logic [31:0] range_rnd;
    logic [31:0] range_d;

    assign sq_rem[0] = sum_sq;
    assign sq_root[0] = 64'd0;

    generate
        for (genvar k = 0; k < SQRT_CELLS; k++)
        begin : g_sqrt
            c2s_sqrt_cell #(.BIT_POS(62 - 2 * k)) u_cell (
                .clk      (clk),
                .rem_in   (sq_rem[k]),
                .root_in  (sq_root[k]),
                .rem_reg  (sq_rem[k+1]),
                .root_reg (sq_root[k+1])
            );
        end
    endgenerate

    assign range_rnd = sq_root[SQRT_CELLS][31:0]
                     + 32'(sq_rem[SQRT_CELLS] > sq_root[SQRT_CELLS]);

    c2s_delay #(.WIDTH(32), .DEPTH(RANGE_DLY)) u_range_dly (
        .clk (clk),
        .d   (range_rnd),
        .q   (range_d)
    );

    // Angles: azimuth chain on (|x|, |y|), then inclination chain on (K|z|, K rho).
    logic [63:0] c1_x [CORDIC_STAGES+1];
    logic [63:0] c1_y [CORDIC_STAGES+1];
    logic [63:0] c1_a [CORDIC_STAGES+1];
    logic [63:0] c2_x [CORDIC_STAGES+1];
    logic [63:0] c2_y [CORDIC_STAGES+1];
    logic [63:0] c2_a [CORDIC_STAGES+1];
    logic [63:0] azim_acc_d;
    c2s_flags_t  fl_d;

    assign c1_x[0] = {3'b000, mx2_reg, 29'd0};
    assign c1_y[0] = {3'b000, my2_reg, 29'd0};
    assign c1_a[0] = 64'd0;
    assign c2_y[0] = c1_x[CORDIC_STAGES];
    assign c2_a[0] = 64'd0;

    c2s_delay #(.WIDTH(64), .DEPTH(CORDIC_STAGES)) u_zk_dly (
        .clk (clk),
        .d   (zk2_reg),
        .q   (c2_x[0])
    );

    c2s_delay #(.WIDTH(64), .DEPTH(CORDIC_STAGES)) u_azim_dly (
        .clk (clk),
        .d   (c1_a[CORDIC_STAGES]),
        .q   (azim_acc_d)
    );

    c2s_delay #(.WIDTH($bits(c2s_flags_t)), .DEPTH(2 * CORDIC_STAGES)) u_flag_dly (
        .clk (clk),
        .d   (fl2_reg),
        .q   (fl_d)
    );

    generate
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            c2s_cordic_cell #(.SHIFT(i)) u_pass1 (
                .clk     (clk),
                .x_in    (c1_x[i]),
                .y_in    (c1_y[i]),
                .acc_in  (c1_a[i]),
                .x_reg   (c1_x[i+1]),
                .y_reg   (c1_y[i+1]),
                .acc_reg (c1_a[i+1])
            );
            c2s_cordic_cell #(.SHIFT(i)) u_pass2 (
                .clk     (clk),
                .x_in    (c2_x[i]),
                .y_in    (c2_y[i]),
                .acc_in  (c2_a[i]),
                .x_reg   (c2_x[i+1]),
                .y_reg   (c2_y[i+1]),
                .acc_reg (c2_a[i+1])
            );
        end
    endgenerate

    // Clamp to the first quadrant and mirror, then round to Q2.29.
    function automatic logic [63:0] fold_angle(logic [63:0] acc, logic mirror);
        logic [63:0] a;
        a = acc[63] ? 64'd0 : acc;
        if (a > HALF_PI)
            a = HALF_PI;
        return mirror ? FULL_PI - a : a;
    endfunction

    logic [63:0] incl_f_reg, azim_f_reg, incl_rnd, azim_rnd;
    logic [31:0] range_f_reg;
    c2s_flags_t  fl_f_reg;

    always_ff @(posedge clk)
    begin
        incl_f_reg <= fold_angle(c2_a[CORDIC_STAGES], fl_d.neg_z);
        azim_f_reg <= fold_angle(azim_acc_d, fl_d.neg_x);
        range_f_reg <= range_d;
        fl_f_reg <= fl_d;
    end

    assign incl_rnd = incl_f_reg + (64'd1 << 31);
    assign azim_rnd = azim_f_reg + (64'd1 << 31);

    always_ff @(posedge clk)
    begin
        range_len <= range_f_reg;
        at_origin <= fl_f_reg.orig;
        incl_angle <= fl_f_reg.orig ? 31'd0 : incl_rnd[62:32];
        if (fl_f_reg.xy_zero)
            azim_angle <= 32'sd0;
        else if (fl_f_reg.neg_y)
            azim_angle <= $signed(32'd0 - azim_rnd[63:32]);
        else
            azim_angle <= $signed(azim_rnd[63:32]);
    end

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an item taken at the pipeline depth");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done && at_origin |-> range_len == 32'd0 && incl_angle == 31'd0
                              && azim_angle == 32'sd0)
        else $error("origin result not all zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !at_origin |-> range_len != 32'd0)
        else $error("non-origin item gave zero range");

    a_incl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> incl_angle <= 31'd1686629713)
        else $error("inclination above pi");

endmodule
